FILE: hw/rtl/tmos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmos_pkg;

  localparam int MAX_READINGS = 16;
  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 8;
  localparam int MEAN_W       = 40;
  localparam int KEPT_W       = 5;

  localparam int IDX_W = (MAX_READINGS > 1) ? $clog2(MAX_READINGS) : 1;
  localparam int CNT_W = $clog2(MAX_READINGS + 1);
  // sum of up to MAX_READINGS signed readings, with headroom for the sign
  localparam int ACC_W = DATA_W + $clog2(MAX_READINGS) + 1;
  localparam int DVD_W = ACC_W + FRAC_W;
  localparam int DCNT_W = $clog2(DVD_W);

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
  } tmos_in_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_value;
    logic [KEPT_W-1:0]        kept_count;
    logic                     overflowed;
  } tmos_out_t;

  // microcode
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SETUP,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_MARK,
    OP_SUM_INIT,
    OP_SUM,
    OP_DIV_INIT,
    OP_DIV,
    OP_EMIT
  } tmos_op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_WAIT,
    C_KZERO,
    C_IDX_MORE,
    C_PICKS_MORE,
    C_DIV_MORE
  } tmos_cond_e;

  typedef struct packed {
    tmos_op_e         op;
    tmos_cond_e       cond;
    logic [PC_W-1:0]  target;
  } tmos_uword_t;

  localparam logic [PC_W-1:0] PC_IDLE      = PC_W'(0);
  localparam logic [PC_W-1:0] PC_SETUP     = PC_W'(1);
  localparam logic [PC_W-1:0] PC_SCAN_INIT = PC_W'(2);
  localparam logic [PC_W-1:0] PC_SCAN      = PC_W'(3);
  localparam logic [PC_W-1:0] PC_MARK      = PC_W'(4);
  localparam logic [PC_W-1:0] PC_SUM_INIT  = PC_W'(5);
  localparam logic [PC_W-1:0] PC_SUM       = PC_W'(6);
  localparam logic [PC_W-1:0] PC_DIV_INIT  = PC_W'(7);
  localparam logic [PC_W-1:0] PC_DIV       = PC_W'(8);
  localparam logic [PC_W-1:0] PC_EMIT      = PC_W'(9);

  // Control store: jump to target when cond holds, else fall through.
  function automatic tmos_uword_t tmos_ucode(logic [PC_W-1:0] pc);
    tmos_uword_t uw;
    case (pc)
      PC_IDLE:      uw = '{op: OP_IDLE,      cond: C_WAIT,       target: PC_IDLE};
      PC_SETUP:     uw = '{op: OP_SETUP,     cond: C_KZERO,      target: PC_SUM_INIT};
      PC_SCAN_INIT: uw = '{op: OP_SCAN_INIT, cond: C_NEVER,      target: PC_IDLE};
      PC_SCAN:      uw = '{op: OP_SCAN,      cond: C_IDX_MORE,   target: PC_SCAN};
      PC_MARK:      uw = '{op: OP_MARK,      cond: C_PICKS_MORE, target: PC_SCAN_INIT};
      PC_SUM_INIT:  uw = '{op: OP_SUM_INIT,  cond: C_NEVER,      target: PC_IDLE};
      PC_SUM:       uw = '{op: OP_SUM,       cond: C_IDX_MORE,   target: PC_SUM};
      PC_DIV_INIT:  uw = '{op: OP_DIV_INIT,  cond: C_NEVER,      target: PC_IDLE};
      PC_DIV:       uw = '{op: OP_DIV,       cond: C_DIV_MORE,   target: PC_DIV};
      PC_EMIT:      uw = '{op: OP_EMIT,      cond: C_ALWAYS,     target: PC_IDLE};
      default:      uw = '{op: OP_IDLE,      cond: C_ALWAYS,     target: PC_IDLE};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/trimmed_mean_of_samples_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Trimmed mean of a burst of signed 32-bit readings. Each transaction (start
// high while busy is low) loads one reading in a single cycle; up to
// MAX_READINGS are kept and later ones are dropped and flagged. The transaction
// with last_sample set starts the burst evaluation: a small microcoded
// sequencer drops the floor(n/4) largest and floor(n/4) smallest of the n
// stored readings by walking the store once per pick, sums the rest and
// runs a one-bit-per-cycle divider on a DVD_W (45) bit dividend. busy stays
// high from the cycle after the last transaction until done_o rises.
// The result is on result_o while done_o is high for exactly one cycle and
// must be captured then, since the receiver cannot stall the block.
module trimmed_mean_of_samples_top
  import tmos_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire tmos_in_t  item_i,
  output logic           busy,
  output logic           done_o,
  output tmos_out_t      result_o
);

  tmos_uword_t uw;

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             dropped_q, dropped_d;
  logic [MAX_READINGS-1:0] excl_q, excl_d;
  logic             done_q, done_d;

  logic [DATA_W-1:0] store_q [MAX_READINGS];

  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         pick_q, pick_d;
  logic                     found_q, found_d;
  logic signed [DATA_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]         at_q, at_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]         kept_q, kept_d;
  logic                     neg_q, neg_d;
  logic [DVD_W-1:0]         quo_q, quo_d;
  logic [CNT_W-1:0]         rem_q, rem_d;
  logic [DCNT_W-1:0]        dcnt_q, dcnt_d;
  tmos_out_t                res_q, res_d;

  logic                     accept;
  logic                     jump;
  logic [CNT_W-1:0]         k_w, two_k;
  logic [CNT_W-1:0]         idx_nxt;
  logic signed [DATA_W-1:0] rd;
  logic                     rd_excl;
  logic                     want_max, better;
  logic [ACC_W-1:0]         mag;
  logic [CNT_W:0]           trial;
  logic                     ge;
  logic [DVD_W-1:0]         quo_signed;

  assign uw     = tmos_ucode(pc_q);
  assign busy   = (pc_q != PC_IDLE);
  assign accept = start && !busy;

  assign k_w     = cnt_q >> 2;
  assign two_k   = k_w << 1;
  assign idx_nxt = CNT_W'(idx_q) + CNT_W'(1);
  assign rd      = signed'(store_q[idx_q]);
  assign rd_excl = excl_q[idx_q];

  assign want_max = (pick_q < k_w);
  assign better   = want_max ? (rd > best_q) : (rd < best_q);

  assign mag        = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign trial      = {rem_q, quo_q[DVD_W-1]};
  assign ge         = (trial >= {1'b0, kept_q});
  assign quo_signed = neg_q ? (~quo_q + DVD_W'(1)) : quo_q;

  always_comb begin
    case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_WAIT:       jump = !(accept && item_i.last_sample);
      C_KZERO:      jump = (k_w == '0);
      C_IDX_MORE:   jump = (idx_nxt < cnt_q);
      C_PICKS_MORE: jump = ((pick_q + CNT_W'(1)) < two_k);
      C_DIV_MORE:   jump = (dcnt_q != '0);
      default:      jump = 1'b1;
    endcase
    pc_d = jump ? uw.target : (pc_q + PC_W'(1));
  end

  always_comb begin
    cnt_d     = cnt_q;
    dropped_d = dropped_q;
    excl_d    = excl_q;
    done_d    = 1'b0;
    idx_d     = idx_q;
    pick_d    = pick_q;
    found_d   = found_q;
    best_d    = best_q;
    at_d      = at_q;
    acc_d     = acc_q;
    kept_d    = kept_q;
    neg_d     = neg_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    res_d     = res_q;

    case (uw.op)
      OP_IDLE: begin
        if (accept) begin
          if (cnt_q < CNT_W'(MAX_READINGS)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
        end
      end
      OP_SETUP: begin
        excl_d = '0;
        pick_d = '0;
      end
      OP_SCAN_INIT: begin
        idx_d   = '0;
        found_d = 1'b0;
      end
      OP_SCAN: begin
        if (!rd_excl && (!found_q || better)) begin
          found_d = 1'b1;
          best_d  = rd;
          at_d    = idx_q;
        end
        idx_d = idx_q + IDX_W'(1);
      end
      OP_MARK: begin
        excl_d[at_q] = 1'b1;
        pick_d       = pick_q + CNT_W'(1);
      end
      OP_SUM_INIT: begin
        idx_d  = '0;
        acc_d  = '0;
        kept_d = '0;
      end
      OP_SUM: begin
        if (!rd_excl) begin
          acc_d  = acc_q + ACC_W'(rd);
          kept_d = kept_q + CNT_W'(1);
        end
        idx_d = idx_q + IDX_W'(1);
      end
      OP_DIV_INIT: begin
        neg_d  = acc_q[ACC_W-1];
        quo_d  = {mag, FRAC_W'(0)};
        rem_d  = '0;
        dcnt_d = DCNT_W'(DVD_W - 1);
      end
      OP_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_d  = ge ? CNT_W'(trial - {1'b0, kept_q}) : CNT_W'(trial);
        quo_d  = {quo_q[DVD_W-2:0], ge};
        dcnt_d = dcnt_q - DCNT_W'(1);
      end
      OP_EMIT: begin
        res_d.mean_value = signed'(quo_signed[MEAN_W-1:0]);
        res_d.kept_count = KEPT_W'(kept_q);
        res_d.overflowed = dropped_q;
        done_d           = 1'b1;
        cnt_d            = '0;
        dropped_d        = 1'b0;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= PC_IDLE;
      cnt_q     <= '0;
      dropped_q <= 1'b0;
      excl_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      cnt_q     <= cnt_d;
      dropped_q <= dropped_d;
      excl_q    <= excl_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q < CNT_W'(MAX_READINGS))) begin
      store_q[cnt_q[IDX_W-1:0]] <= item_i.sample;
    end
    idx_q   <= idx_d;
    pick_q  <= pick_d;
    found_q <= found_d;
    best_q  <= best_d;
    at_q    <= at_d;
    acc_q   <= acc_d;
    kept_q  <= kept_d;
    neg_q   <= neg_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dcnt_q  <= dcnt_d;
    res_q   <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_done_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.kept_count != '0) && !busy)
    else $error("result with no kept readings or while busy");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> (cnt_q == CNT_W'(MAX_READINGS)))
    else $error("reading dropped while store not full");

  a_mark_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_MARK) |-> found_q)
    else $error("exclusion without a candidate");

  a_excl_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_EMIT) |-> ($countones(excl_q) == int'(two_k)))
    else $error("wrong number of excluded readings");

endmodule

`default_nettype wire

FILE: verif/tb_trimmed_mean_of_samples_top.sv
`timescale 1ns / 1ps

module tb_trimmed_mean_of_samples_top;
  import tmos_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 900;

  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;

  typedef enum int {
    MIX_FULL,   // any 32-bit value
    MIX_SMALL,  // narrow range, lots of ties
    MIX_EDGE,   // rails and values near zero
    MIX_BLEND
  } mix_e;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  tmos_in_t  item_i = '0;
  logic      busy;
  logic      done_o;
  tmos_out_t result_o;

  trimmed_mean_of_samples_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // shadow of the block's burst state
  logic signed [DATA_W-1:0] held [MAX_READINGS];
  int unsigned held_cnt = 0;
  logic        spilled  = 1'b0;

  tmos_out_t   pending_means[$];
  tmos_out_t   want;
  int unsigned errors   = 0;
  int unsigned cycles   = 0;
  int unsigned run_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, pending_means.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Cut k largest, then k smallest of the rest (first occurrence on ties),
  // then average what is left in Q.8, truncated toward zero.
  function automatic tmos_out_t trimmed_mean(input int unsigned n, input logic drop);
    logic [MAX_READINGS-1:0] cut;
    int unsigned k, kept, at;
    bit          found;
    longint      best, total;
    tmos_out_t   r;
    cut = '0;
    k = n / 4;
    for (int p = 0; p < 2 * k; p++) begin
      found = 1'b0;
      at    = 0;
      best  = 0;
      for (int i = 0; i < n; i++) begin
        if (!cut[i] && (!found || ((p < k) ? (held[i] > best) : (held[i] < best)))) begin
          found = 1'b1;
          best  = held[i];
          at    = i;
        end
      end
      if (found) cut[at] = 1'b1;
    end
    total = 0;
    kept  = 0;
    for (int i = 0; i < n; i++) begin
      if (!cut[i]) begin
        total += held[i];
        kept++;
      end
    end
    r.mean_value = MEAN_W'((total * 256) / longint'(kept));
    r.kept_count = KEPT_W'(kept);
    r.overflowed = drop;
    return r;
  endfunction

  // sender pacing: runs of back-to-back transactions broken by short gaps
  task automatic pace();
    if (run_left > 0) begin
      run_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic load_reading(input logic signed [DATA_W-1:0] value, input logic last);
    item_i <= '{sample: value, last_sample: last};
    start  <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (held_cnt < MAX_READINGS) begin
      held[held_cnt] = value;
      held_cnt++;
    end else begin
      spilled = 1'b1;
    end
    if (last) begin
      pending_means.push_back(trimmed_mean(held_cnt, spilled));
      held_cnt = 0;
      spilled  = 1'b0;
    end
    pace();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_means.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending: mean=%0d kept=%0d ovf=%b", $time,
                 $signed(result_o.mean_value), result_o.kept_count, result_o.overflowed);
      end else begin
        want = pending_means.pop_front();
        if (result_o.mean_value !== want.mean_value) begin
          errors++;
          $display("%0t: mean_value expected %0d got %0d", $time,
                   $signed(want.mean_value), $signed(result_o.mean_value));
        end
        if (result_o.kept_count !== want.kept_count) begin
          errors++;
          $display("%0t: kept_count expected %0d got %0d", $time,
                   want.kept_count, result_o.kept_count);
        end
        if (result_o.overflowed !== want.overflowed) begin
          errors++;
          $display("%0t: overflowed expected %b got %b", $time,
                   want.overflowed, result_o.overflowed);
        end
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] random_reading(input mix_e mix);
    logic signed [DATA_W-1:0] v;
    case (mix)
      MIX_SMALL: v = DATA_W'(int'($urandom_range(0, 8)) - 4);
      MIX_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = S_MAX;
          1:       v = S_MIN;
          2:       v = S_MAX - DATA_W'($urandom_range(0, 3));
          3:       v = S_MIN + DATA_W'($urandom_range(0, 3));
          default: v = DATA_W'(int'($urandom_range(0, 2)) - 1);
        endcase
      end
      MIX_BLEND: v = $urandom_range(0, 1) ? $urandom() : DATA_W'(int'($urandom_range(0, 8)) - 4);
      default:   v = $urandom();
    endcase
    return v;
  endfunction

  task automatic test_single_extremes();
    load_reading(S_MAX, 1'b1);
    load_reading(S_MIN, 1'b1);
  endtask

  // -512/3 must truncate to -170, not floor to -171
  task automatic test_negative_truncation();
    load_reading(-32'sd1, 1'b0);
    load_reading(-32'sd1, 1'b0);
    load_reading(32'sd0, 1'b1);
  endtask

  // equal extremes: only the first of each pair is cut
  task automatic test_ties_and_trim();
    load_reading(S_MAX, 1'b0);
    load_reading(S_MAX, 1'b0);
    load_reading(S_MIN, 1'b0);
    load_reading(S_MIN, 1'b1);
  endtask

  // store full when the final reading arrives: it is dropped and flagged
  task automatic test_store_overflow();
    for (int i = 0; i <= MAX_READINGS; i++) begin
      load_reading((i % 2) ? S_MIN : S_MAX, i == MAX_READINGS);
    end
  endtask

  task automatic test_random_bursts(input int unsigned items);
    int unsigned sent, len;
    mix_e        mix;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_READINGS + 1, MAX_READINGS + 8)
                                        : $urandom_range(1, MAX_READINGS);
      mix = mix_e'($urandom_range(0, 3));
      for (int i = 0; i < len; i++) begin
        load_reading(random_reading(mix), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_extremes();
    test_negative_truncation();
    test_ties_and_trim();
    test_store_overflow();
    test_random_bursts(RANDOM_ITEMS);
    start <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
